// ===== rtl/smb_pkg.sv =====
`default_nettype none

package smb_pkg;

    localparam int VALUE_BITS = 16;
    localparam int LANES      = 4;
    localparam int EPOCH_BITS = 8;
    localparam int DATA_W     = LANES * VALUE_BITS;
    localparam int WORD_W     = DATA_W + EPOCH_BITS;
    localparam int NUM_W      = 9;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_SCATTER = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [EPOCH_BITS-1:0]        t_epoch;

endpackage

`default_nettype wire

// ===== rtl/scatter_max_buckets.sv =====
// Bucket table of per-lane maxima over four signed Q8.8 lanes per chunk.
// Input channel (i_in_valid / o_in_ready) takes items with i_cmd: clear all,
// scatter four values into one bucket chunk by per-lane maximum, or read one
// bucket chunk. Only a read produces a result item on the output channel
// (o_out_valid / i_out_ready), with o_touched low and zero maxima for an
// untouched or out-of-range chunk. i_cfg_we writes num_buckets at once.
// Scatter and read items pass through the registered read of the single table
// memory and then the write-back or the result load; no item is taken while
// one is in progress, and a read waits while the output holds an untaken result.
// Clear items and out-of-range scatters finish in the idle state. Clears
// advance an 8-bit epoch stored with each entry; every 255th clear instead
// runs a sweep over all BUCKETS*CHUNKS entries (2048 by default) during which
// no item is accepted. The same sweep runs after reset. A result waits in the
// output register while the receiver stalls; further items are still taken
// until another read needs the output register.
`default_nettype none

module scatter_max_buckets #(
    parameter int BUCKETS = 256,
    parameter int CHUNKS  = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [1:0]                  i_cmd,
    input  wire logic signed [8:0]           i_bucket,
    input  wire logic [2:0]                  i_chunk,
    input  wire logic signed [15:0]          i_value0,
    input  wire logic signed [15:0]          i_value1,
    input  wire logic signed [15:0]          i_value2,
    input  wire logic signed [15:0]          i_value3,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [15:0]               o_max0,
    output logic signed [15:0]               o_max1,
    output logic signed [15:0]               o_max2,
    output logic signed [15:0]               o_max3,
    output logic                             o_touched,
    input  wire logic                        i_cfg_we,
    input  wire logic [smb_pkg::NUM_W-1:0]   i_cfg_data
);

    localparam int DEPTH = BUCKETS * CHUNKS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_sweep_addr, n_sweep_addr;
    smb_pkg::t_epoch            r_epoch, n_epoch;
    logic                       r_out_valid, n_out_valid;
    logic [smb_pkg::NUM_W-1:0]  r_num_buckets;
    logic [AW-1:0]              r_addr, n_addr;
    logic                       r_is_read, n_is_read;
    logic                       r_hit, n_hit;
    smb_pkg::t_value            r_values [smb_pkg::LANES];
    smb_pkg::t_value            n_values [smb_pkg::LANES];
    smb_pkg::t_value            r_max [smb_pkg::LANES];
    smb_pkg::t_value            n_max [smb_pkg::LANES];
    logic                       r_touched, n_touched;

    smb_pkg::t_value            in_values [smb_pkg::LANES];
    smb_pkg::t_value            old_values [smb_pkg::LANES];
    smb_pkg::t_value            merge_values [smb_pkg::LANES];
    smb_pkg::t_value            read_values [smb_pkg::LANES];
    logic [smb_pkg::DATA_W-1:0] merge_word;

    logic                       loc_ok;
    logic [31:0]                loc_entry;
    logic [AW-1:0]              loc_addr;
    logic                       entry_touched;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [smb_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [smb_pkg::WORD_W-1:0] ram_rdata;

    assign in_values[0] = i_value0;
    assign in_values[1] = i_value1;
    assign in_values[2] = i_value2;
    assign in_values[3] = i_value3;

    assign loc_ok = !i_bucket[8]
                 && ({1'b0, i_bucket[7:0]} < r_num_buckets)
                 && (32'(i_bucket[7:0]) < BUCKETS)
                 && (32'(i_chunk) < CHUNKS);
    assign loc_entry = 32'(i_bucket[7:0]) * 32'(CHUNKS) + 32'(i_chunk);
    assign loc_addr  = loc_entry[AW-1:0];

    assign entry_touched = r_hit
        && (ram_rdata[smb_pkg::WORD_W-1:smb_pkg::DATA_W] == r_epoch);

    for (genvar g = 0; g < smb_pkg::LANES; g++) begin : g_lane
        assign old_values[g] = ram_rdata[g*smb_pkg::VALUE_BITS +: smb_pkg::VALUE_BITS];
        assign merge_word[g*smb_pkg::VALUE_BITS +: smb_pkg::VALUE_BITS] = merge_values[g];

        smb_lane u_lane (
            .i_old     (old_values[g]),
            .i_new     (r_values[g]),
            .i_touched (entry_touched),
            .o_merge   (merge_values[g]),
            .o_read    (read_values[g])
        );
    end

    smb_ram #(
        .WIDTH (smb_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_sweep_addr = r_sweep_addr;
        n_epoch      = r_epoch;
        n_out_valid  = r_out_valid;
        n_addr       = r_addr;
        n_is_read    = r_is_read;
        n_hit        = r_hit;
        n_values     = r_values;
        n_max        = r_max;
        n_touched    = r_touched;
        ram_we       = 1'b0;
        ram_waddr    = r_sweep_addr;
        ram_wdata    = '0;
        ram_raddr    = (r_state == S_IDLE) ? loc_addr : r_addr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_SWEEP: begin
                ram_we       = 1'b1;
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        smb_pkg::CMD_CLEAR: begin
                            if (r_epoch == '1) begin
                                n_state      = S_SWEEP;
                                n_sweep_addr = '0;
                                n_epoch      = smb_pkg::t_epoch'(1);
                            end else begin
                                n_epoch = r_epoch + 1'b1;
                            end
                        end
                        smb_pkg::CMD_SCATTER: begin
                            if (loc_ok) begin
                                n_state   = S_EXEC;
                                n_is_read = 1'b0;
                                n_hit     = 1'b1;
                                n_addr    = loc_addr;
                                n_values  = in_values;
                            end
                        end
                        smb_pkg::CMD_READ: begin
                            n_state   = S_EXEC;
                            n_is_read = 1'b1;
                            n_hit     = loc_ok;
                            n_addr    = loc_addr;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (!r_is_read) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_addr;
                    ram_wdata = {r_epoch, merge_word};
                    n_state   = S_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_max       = read_values;
                    n_touched   = entry_touched;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state      = S_SWEEP;
                n_sweep_addr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_sweep_addr  <= '0;
            r_epoch       <= smb_pkg::t_epoch'(1);
            r_out_valid   <= 1'b0;
            r_num_buckets <= smb_pkg::NUM_W'(256);
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_epoch      <= n_epoch;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_num_buckets <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_is_read <= n_is_read;
        r_hit     <= n_hit;
        r_values  <= n_values;
        r_max     <= n_max;
        r_touched <= n_touched;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_max0      = r_max[0];
    assign o_max1      = r_max[1];
    assign o_max2      = r_max[2];
    assign o_max3      = r_max[3];
    assign o_touched   = r_touched;

endmodule

`default_nettype wire

// ===== rtl/smb_ram.sv =====
`default_nettype none

module smb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/smb_lane.sv =====
`default_nettype none

module smb_lane (
    input  wire smb_pkg::t_value i_old,
    input  wire smb_pkg::t_value i_new,
    input  wire logic            i_touched,
    output smb_pkg::t_value      o_merge,
    output smb_pkg::t_value      o_read
);

    // An untouched entry takes the new value as it is.
    assign o_merge = (!i_touched || (i_new > i_old)) ? i_new : i_old;
    assign o_read  = i_touched ? i_old : '0;

endmodule

`default_nettype wire

// ===== bench/smb_checker.sv =====
`default_nettype none

module smb_checker #(
    parameter int BUCKETS = 256,
    parameter int CHUNKS  = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [8:0]       i_bucket,
    input  wire logic [2:0]              i_chunk,
    input  wire logic signed [15:0]      i_value0,
    input  wire logic signed [15:0]      i_value1,
    input  wire logic signed [15:0]      i_value2,
    input  wire logic signed [15:0]      i_value3,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic signed [15:0]      i_max0,
    input  wire logic signed [15:0]      i_max1,
    input  wire logic signed [15:0]      i_max2,
    input  wire logic signed [15:0]      i_max3,
    input  wire logic                    i_touched,
    input  wire logic                    i_cfg_we,
    input  wire logic [smb_pkg::NUM_W-1:0] i_cfg_data,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = BUCKETS * CHUNKS;

    typedef struct packed {
        logic            touched;
        smb_pkg::t_value m3;
        smb_pkg::t_value m2;
        smb_pkg::t_value m1;
        smb_pkg::t_value m0;
    } t_chunk_read;

    smb_pkg::t_value           chunk_max [0:ENTRIES-1][0:smb_pkg::LANES-1];
    bit                        chunk_hit [0:ENTRIES-1];
    logic [smb_pkg::NUM_W-1:0] bucket_limit = smb_pkg::NUM_W'(256);
    t_chunk_read               read_queue [$];
    int                        fail_count   = 0;
    int                        pending      = 0;
    int                        result_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_result_count = result_count;

    function automatic bit find_entry(input logic signed [8:0] b, input logic [2:0] c,
                                      output int idx);
        idx = 0;
        if (b < 0 || int'(b) >= int'(bucket_limit) || int'(b) >= BUCKETS) begin
            return 1'b0;
        end
        if (int'(c) >= CHUNKS) begin
            return 1'b0;
        end
        idx = int'(b) * CHUNKS + int'(c);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("%0t ns: read result %0d, %s is %0d, expected %0d",
                 $time, result_count, what, got, want);
    endtask

    always @(posedge i_clk) begin : predict_and_compare
        int              idx;
        t_chunk_read     want;
        smb_pkg::t_value lane_in [0:smb_pkg::LANES-1];

        if (!i_rst_n) begin
            foreach (chunk_hit[k]) begin
                chunk_hit[k] = 1'b0;
            end
            bucket_limit = smb_pkg::NUM_W'(256);
            read_queue.delete();
        end else begin
            if (i_cfg_we) begin
                bucket_limit = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                result_count++;
                if (read_queue.size() == 0) begin
                    report_mismatch("unrequested result, touched", int'(i_touched), 0);
                end else begin
                    want = read_queue.pop_front();
                    if (i_max0 !== want.m0) report_mismatch("max0", int'(i_max0), int'(want.m0));
                    if (i_max1 !== want.m1) report_mismatch("max1", int'(i_max1), int'(want.m1));
                    if (i_max2 !== want.m2) report_mismatch("max2", int'(i_max2), int'(want.m2));
                    if (i_max3 !== want.m3) report_mismatch("max3", int'(i_max3), int'(want.m3));
                    if (i_touched !== want.touched) begin
                        report_mismatch("touched", int'(i_touched), int'(want.touched));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                lane_in[0] = i_value0;
                lane_in[1] = i_value1;
                lane_in[2] = i_value2;
                lane_in[3] = i_value3;
                case (i_cmd)
                    smb_pkg::CMD_CLEAR: begin
                        foreach (chunk_hit[k]) begin
                            chunk_hit[k] = 1'b0;
                        end
                    end
                    smb_pkg::CMD_SCATTER: begin
                        if (find_entry(i_bucket, i_chunk, idx)) begin
                            for (int l = 0; l < smb_pkg::LANES; l++) begin
                                if (!chunk_hit[idx] || lane_in[l] > chunk_max[idx][l]) begin
                                    chunk_max[idx][l] = lane_in[l];
                                end
                            end
                            chunk_hit[idx] = 1'b1;
                        end
                    end
                    smb_pkg::CMD_READ: begin
                        want = '0;
                        if (find_entry(i_bucket, i_chunk, idx) && chunk_hit[idx]) begin
                            want.touched = 1'b1;
                            want.m0      = chunk_max[idx][0];
                            want.m1      = chunk_max[idx][1];
                            want.m2      = chunk_max[idx][2];
                            want.m3      = chunk_max[idx][3];
                        end
                        read_queue.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending = read_queue.size();
    end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int STORM_ITEMS     = 600;
    localparam int WATCHDOG_LIMIT  = 8192;
    localparam int SETTLE_CYCLES   = 12;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [1:0]                cmd       = smb_pkg::CMD_CLEAR;
    logic signed [8:0]         bucket    = '0;
    logic [2:0]                chunk     = '0;
    smb_pkg::t_value           value0    = '0;
    smb_pkg::t_value           value1    = '0;
    smb_pkg::t_value           value2    = '0;
    smb_pkg::t_value           value3    = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    smb_pkg::t_value           max0;
    smb_pkg::t_value           max1;
    smb_pkg::t_value           max2;
    smb_pkg::t_value           max3;
    logic                      touched;
    logic                      cfg_we    = 1'b0;
    logic [smb_pkg::NUM_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int result_count;

    bit                gaps_on   = 1'b0;
    bit                stalls_on = 1'b0;
    int unsigned       bucket_limit_now = 256;
    logic signed [8:0] hot_bucket [0:3];
    logic [2:0]        hot_chunk [0:1];
    int                n_clear    = 0;
    int                n_scatter  = 0;
    int                n_read     = 0;
    int                n_reserved = 0;
    int                n_settings = 1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    scatter_max_buckets u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_cmd       (cmd),
        .i_bucket    (bucket),
        .i_chunk     (chunk),
        .i_value0    (value0),
        .i_value1    (value1),
        .i_value2    (value2),
        .i_value3    (value3),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_max0      (max0),
        .o_max1      (max1),
        .o_max2      (max2),
        .o_max3      (max3),
        .o_touched   (touched),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    smb_checker u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_cmd          (cmd),
        .i_bucket       (bucket),
        .i_chunk        (chunk),
        .i_value0       (value0),
        .i_value1       (value1),
        .i_value2       (value2),
        .i_value3       (value3),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_max0         (max0),
        .i_max1         (max1),
        .i_max2         (max2),
        .i_max3         (max3),
        .i_touched      (touched),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : result_sink
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            stall = stalls_on ? $urandom_range(4, 0) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!(out_valid && out_ready));
        end
    end

    // Entered and left at a falling edge; the item stays on the port until taken.
    task automatic push(input logic [1:0] c, input logic signed [8:0] b, input logic [2:0] ch,
                        input smb_pkg::t_value a0, input smb_pkg::t_value a1,
                        input smb_pkg::t_value a2, input smb_pkg::t_value a3);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(4, 0) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        bucket   <= b;
        chunk    <= ch;
        value0   <= a0;
        value1   <= a1;
        value2   <= a2;
        value3   <= a3;
        do @(posedge i_clk); while (!(in_valid && in_ready));
        @(negedge i_clk);
        case (c)
            smb_pkg::CMD_CLEAR:   n_clear++;
            smb_pkg::CMD_SCATTER: n_scatter++;
            smb_pkg::CMD_READ:    n_read++;
            default:              n_reserved++;
        endcase
    endtask

    task automatic scatter(input logic signed [8:0] b, input logic [2:0] ch,
                           input smb_pkg::t_value a0, input smb_pkg::t_value a1,
                           input smb_pkg::t_value a2, input smb_pkg::t_value a3);
        push(smb_pkg::CMD_SCATTER, b, ch, a0, a1, a2, a3);
    endtask

    task automatic read_chunk(input logic signed [8:0] b, input logic [2:0] ch);
        push(smb_pkg::CMD_READ, b, ch, '0, '0, '0, '0);
    endtask

    task automatic clear_all();
        push(smb_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0);
    endtask

    function automatic smb_pkg::t_value pick_value();
        case ($urandom_range(7, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return smb_pkg::t_value'($urandom);
        endcase
    endfunction

    function automatic logic signed [8:0] pick_bucket();
        case ($urandom_range(9, 0))
            0:       return 9'($urandom_range(511, 256));
            1:       return 9'($urandom_range(511, 0));
            2:       return 9'(bucket_limit_now);
            3:       return 9'(bucket_limit_now - 1);
            default: return hot_bucket[$urandom_range(3, 0)];
        endcase
    endfunction

    function automatic logic [2:0] pick_chunk();
        if ($urandom_range(1, 0) == 0) begin
            return hot_chunk[$urandom_range(1, 0)];
        end
        return 3'($urandom_range(7, 0));
    endfunction

    // Most traffic lands on a few buckets so that scatters pile up and reads find them.
    task automatic choose_hot_set();
        int unsigned usable;
        usable = (bucket_limit_now > 256) ? 256 : bucket_limit_now;
        if (usable == 0) begin
            foreach (hot_bucket[k]) hot_bucket[k] = 9'($urandom_range(511, 0));
        end else begin
            hot_bucket[0] = '0;
            hot_bucket[1] = 9'(usable - 1);
            hot_bucket[2] = 9'($urandom_range(usable - 1, 0));
            hot_bucket[3] = 9'($urandom_range(usable - 1, 0));
        end
        hot_chunk[0] = 3'($urandom_range(7, 0));
        hot_chunk[1] = 3'($urandom_range(7, 0));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // A closing read guarantees that every earlier item, a sweep included, is done.
    task automatic set_bucket_limit(input int unsigned n);
        read_chunk(pick_bucket(), pick_chunk());
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= smb_pkg::NUM_W'(n);
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        bucket_limit_now = n;
        n_settings++;
        choose_hot_set();
    endtask

    task automatic random_items(input int count, input int clear_pct);
        int         done;
        int         r;
        int         scatter_pct;
        logic [1:0] c;
        done = 0;
        scatter_pct = (100 - clear_pct - 2) * 55 / 100;
        while (done < count) begin
            if (done % 25 == 0) begin
                gaps_on   = ($urandom_range(3, 0) != 0);
                stalls_on = ($urandom_range(3, 0) != 0);
            end
            r = $urandom_range(99, 0);
            if (r < clear_pct) begin
                c = smb_pkg::CMD_CLEAR;
            end else if (r < clear_pct + 2) begin
                c = CMD_RESERVED;
            end else if (r < clear_pct + 2 + scatter_pct) begin
                c = smb_pkg::CMD_SCATTER;
            end else begin
                c = smb_pkg::CMD_READ;
            end
            push(c, pick_bucket(), pick_chunk(), pick_value(), pick_value(), pick_value(),
                 pick_value());
            if (c != CMD_RESERVED) begin
                done++;
            end
        end
    endtask

    initial begin : stimulus
        int unsigned limits [0:5];
        limits[0] = 0;
        limits[1] = 1;
        limits[2] = 255;
        limits[3] = 511;
        limits[4] = $urandom_range(254, 2);
        limits[5] = 256;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        choose_hot_set();

        stalls_on = 1'b1;
        read_chunk(0, 0);
        scatter(0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        read_chunk(0, 0);
        scatter(0, 0, 16'sh7fff, 16'sh8000, 0, -1);
        scatter(0, 0, -5, 100, -1, 16'sh8000);
        read_chunk(0, 0);
        scatter(255, 7, 1, 2, 3, 4);
        read_chunk(255, 7);
        scatter(-1, 0, 9, 9, 9, 9);
        scatter(-256, 3, 9, 9, 9, 9);
        read_chunk(-1, 0);
        read_chunk(-256, 3);
        push(CMD_RESERVED, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        read_chunk(0, 1);
        clear_all();
        read_chunk(0, 0);
        read_chunk(255, 7);
        scatter(0, 0, 16'sh8000, -2, 16'sh8000, 5);
        read_chunk(0, 0);
        scatter(128, 4, pick_value(), pick_value(), pick_value(), pick_value());
        read_chunk(128, 4);
        clear_all();
        clear_all();
        read_chunk(128, 4);

        foreach (limits[k]) begin
            set_bucket_limit(limits[k]);
            random_items(ITEMS_PER_PHASE, 6);
        end
        // A run of mostly clears carries old entries across the clear counter wrap.
        random_items(STORM_ITEMS, 80);
        read_chunk(pick_bucket(), pick_chunk());
        drain();

        $display("Sent %0d clears, %0d scatters, %0d reads and %0d reserved items",
                 n_clear, n_scatter, n_read, n_reserved);
        $display("over %0d bucket limit settings; %0d read results checked, %0d mismatches.",
                 n_settings, result_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
